// ===== rtl/eps_pkg.sv =====
`default_nettype none

package eps_pkg;

    // Number of encoder channels held in state
    localparam int WHEELS = 2;
    localparam int WIDX   = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    // Register reset value
    localparam logic [15:0] SCALE_RESET = 16'd1000;

    // Operation codes
    localparam logic OP_POSITION = 1'b0;
    localparam logic OP_SPEED    = 1'b1;

    // Divider geometry
    localparam int DIV_W   = 32;
    localparam int DIV_CNT = $clog2(DIV_W + 1);

    typedef struct packed {
        logic        opcode;
        logic        wheel;
        logic [15:0] counter_value;
        logic [31:0] now_ms;
    } eps_in_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] speed;
        logic               no_elapsed_time;
    } eps_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eps_div_status_t;

endpackage

`default_nettype wire

// ===== rtl/eps_divider.sv =====
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle
module eps_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [eps_pkg::DIV_W-1:0]     dividend,
    input  wire logic [eps_pkg::DIV_W-1:0]     divisor,
    output logic      [eps_pkg::DIV_W-1:0]     quotient,
    output eps_pkg::eps_div_status_t           status
);
    import eps_pkg::*;

    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   quot_reg, quot_next;
    logic [DIV_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_CNT-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_W:0]     trial;
    logic [DIV_W:0]     diff;

    // One shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quot_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            quot_next = {quot_reg[DIV_W-2:0], ~diff[DIV_W]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/encoder_position_and_speed.sv =====
`default_nettype none

// Quadrature encoder position and speed per wheel.
// Input channel in_valid/in_ready/in_data carries opcode, wheel, the raw
// 16-bit counter reading and a millisecond timestamp. Each transfer yields
// exactly one result on out_valid/out_ready/out_data: position, speed and a
// flag for a speed read that saw no elapsed time.
// cfg_valid/cfg_ready/cfg_data writes counts_scale; write only when idle.
// One item at a time: in_ready is high only when the sequencer is idle.
// A position read passes the states CALC and FINISH; a speed read also
// passes DIV, where the shared 32-step serial divider (one quotient bit per
// cycle) runs; zero elapsed time skips the divider. in_ready rises
// together with out_valid, so a new item is accepted only after the
// previous result has been registered.
// The result sits in an output register; if the receiver stalls, the next
// item is accepted and computed, then held until the register frees.
// Reset clears the per-wheel count, position and time, sets counts_scale to
// 1000 and leaves no result pending.
module encoder_position_and_speed (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire eps_pkg::eps_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output eps_pkg::eps_out_t     out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [15:0]      cfg_data
);
    import eps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    eps_in_t          item_reg, item_next;
    logic [15:0]      scale_reg;
    logic [15:0]      mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic             none_reg, none_next;
    logic [31:0]      dt_reg, dt_next;
    logic             out_valid_reg, out_valid_next;
    eps_out_t         out_reg, out_next;
    logic             div_cnt_started_reg, div_cnt_started_next;

    logic [15:0]      last_count_reg [WHEELS];
    logic [31:0]      position_reg   [WHEELS];
    logic [31:0]      last_time_reg  [WHEELS];

    logic             wheel_ok;
    logic [WIDX-1:0]  idx;
    logic [15:0]      d16;
    logic             out_free;
    logic             commit;
    logic             div_start;
    logic [31:0]      product;
    logic [31:0]      quotient;
    eps_div_status_t  div_status;
    logic [31:0]      delta32;
    logic [31:0]      pos_new;
    logic [31:0]      speed_val;

    assign wheel_ok  = (32'(item_reg.wheel) < WHEELS);
    assign idx       = wheel_ok ? WIDX'(item_reg.wheel) : '0;
    assign d16       = item_reg.counter_value - last_count_reg[idx];
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Shared divider: scaled count magnitude over elapsed ms
    assign product   = 32'(mag_reg) * 32'(scale_reg);
    assign div_start = (state_reg == S_DIV) && !div_status.busy && !div_status.done
                       && (dt_reg != '0) && (div_cnt_started_reg == 1'b0);

    eps_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (dt_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    // Result of the item
    always_comb
    begin
        delta32   = neg_reg ? (32'd0 - 32'(mag_reg)) : 32'(mag_reg);
        pos_new   = position_reg[idx];
        speed_val = '0;
        if (item_reg.opcode == OP_POSITION)
        begin
            pos_new = position_reg[idx] + delta32;
        end
        else if (!none_reg)
        begin
            speed_val = neg_reg ? (32'd0 - quotient) : quotient;
        end
    end

    assign commit = (state_reg == S_FINISH) && out_free;

    // Sequencer
    always_comb
    begin
        state_next           = state_reg;
        item_next            = item_reg;
        mag_next             = mag_reg;
        neg_next             = neg_reg;
        none_next            = none_reg;
        dt_next              = dt_reg;
        div_cnt_started_next = div_cnt_started_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        out_next             = out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                neg_next             = d16[15];
                mag_next             = d16[15] ? (16'd0 - d16) : d16;
                dt_next              = item_reg.now_ms - last_time_reg[idx];
                none_next            = (item_reg.now_ms == last_time_reg[idx]);
                div_cnt_started_next = 1'b0;
                if (wheel_ok && (item_reg.opcode == OP_SPEED)
                    && (item_reg.now_ms != last_time_reg[idx]))
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV:
            begin
                if (div_start)
                begin
                    div_cnt_started_next = 1'b1;
                end
                if (div_status.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (wheel_ok)
                    begin
                        out_next.position        = pos_new;
                        out_next.speed           = speed_val;
                        out_next.no_elapsed_time = (item_reg.opcode == OP_SPEED) && none_reg;
                    end
                    else
                    begin
                        out_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            out_valid_reg       <= 1'b0;
            div_cnt_started_reg <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            out_valid_reg       <= out_valid_next;
            div_cnt_started_reg <= div_cnt_started_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        none_reg <= none_next;
        dt_reg   <= dt_next;
        out_reg  <= out_next;
    end

    // Scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scale_reg <= cfg_data;
        end
    end

    // Per-wheel state, updated when the result is committed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WHEELS; i++)
            begin
                last_count_reg[i] <= '0;
                position_reg[i]   <= '0;
                last_time_reg[i]  <= '0;
            end
        end
        else if (commit && wheel_ok)
        begin
            last_count_reg[idx] <= item_reg.counter_value;
            if (item_reg.opcode == OP_POSITION)
            begin
                position_reg[idx] <= pos_new;
            end
            else
            begin
                last_time_reg[idx] <= item_reg.now_ms;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/eps_checker.sv =====
`default_nettype none

module eps_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire eps_pkg::eps_out_t out_data
);
    import eps_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // Zero elapsed time reports zero speed
    a_no_time_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.no_elapsed_time |-> out_data.speed == 32'sd0)
        else $error("speed nonzero with no elapsed time");

endmodule

bind encoder_position_and_speed eps_checker u_eps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/tb_encoder_position_and_speed.sv =====
`timescale 1ns / 1ps

module tb_encoder_position_and_speed;
    import eps_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 4;
    // leave margin for a speed read to finish before a register write
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 500;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRESSURE_ITEMS = 12;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    eps_in_t     in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    eps_out_t    out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    // per-wheel shadow of the encoder state and the scale register
    logic [15:0] wheel_count [WHEELS];
    logic [31:0] wheel_pos   [WHEELS];
    logic [31:0] wheel_time  [WHEELS];
    logic [15:0] speed_scale;

    eps_out_t pending_readings[$];
    int       error_count    = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       hold_left      = 0;
    int       quiet_cycles   = 0;

    encoder_position_and_speed dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Expected reading for one item; advances the shadow state
    function automatic eps_out_t predict_reading(input eps_in_t item);
        logic [15:0] delta;
        logic [16:0] mag;
        logic [31:0] elapsed;
        logic [63:0] quotient;
        eps_out_t    reading;
        int          w;
        reading = '0;
        w = item.wheel;
        if (w >= WHEELS)
            return reading;
        delta = item.counter_value - wheel_count[w];
        mag = delta[15] ? (17'h10000 - {1'b0, delta}) : {1'b0, delta};
        wheel_count[w] = item.counter_value;
        if (item.opcode == OP_POSITION)
        begin
            wheel_pos[w] = wheel_pos[w] + {{16{delta[15]}}, delta};
        end
        else
        begin
            elapsed = item.now_ms - wheel_time[w];
            wheel_time[w] = item.now_ms;
            if (elapsed == 32'd0)
            begin
                reading.no_elapsed_time = 1'b1;
            end
            else
            begin
                quotient = (64'(mag) * 64'(speed_scale)) / 64'(elapsed);
                reading.speed = delta[15] ? -quotient[31:0] : quotient[31:0];
            end
        end
        reading.position = wheel_pos[w];
        return reading;
    endfunction

    function automatic eps_in_t make_item(input logic op, input logic wheel,
                                          input logic [15:0] count, input logic [31:0] now);
        eps_in_t item;
        item.opcode        = op;
        item.wheel         = wheel;
        item.counter_value = count;
        item.now_ms        = now;
        return item;
    endfunction

    // Mostly plausible encoder traffic, with some wild counts and timestamps
    function automatic eps_in_t random_reading();
        eps_in_t     item;
        int          w;
        logic [15:0] count;
        logic [31:0] now;
        w = $urandom_range(WHEELS - 1);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: count = wheel_count[w] + 16'($urandom_range(4000)) - 16'd2000;
            6:                count = 16'($urandom);
            7:                count = wheel_count[w] + 16'h7FFF;
            8:                count = wheel_count[w] + 16'h8000;
            default:          count = wheel_count[w];
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: now = wheel_time[w] + $urandom_range(500, 1);
            6:                now = wheel_time[w];
            7:                now = $urandom;
            8:                now = 32'hFFFF_FFFF - $urandom_range(3);
            default:          now = wheel_time[w] + $urandom_range(100000, 1);
        endcase
        item = make_item($urandom_range(1) ? OP_SPEED : OP_POSITION, 1'(w), count, now);
        return item;
    endfunction

    // One input transfer; the prediction is queued when it is accepted
    task automatic send_item(input eps_in_t item);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_readings.push_back(predict_reading(item));
    endtask

    // Drop valid, wait for every reading, then let the block settle
    task automatic wait_for_readings();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_scale(input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        speed_scale = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Count extremes, zero elapsed time, timestamp wrap and scale extremes
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(make_item(OP_SPEED,    1'b0, 16'h0000, 32'h0000_0000));
        send_item(make_item(OP_POSITION, 1'b0, 16'h7FFF, 32'h0000_0000));
        send_item(make_item(OP_POSITION, 1'b0, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_POSITION, 1'b1, 16'hFFFF, 32'h1234_5678));
        send_item(make_item(OP_SPEED,    1'b1, 16'h7FFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_SPEED,    1'b1, 16'h7FFE, 32'h0000_0001));
        send_item(make_item(OP_SPEED,    1'b1, 16'h7FFE, 32'h0000_0001));
        send_item(make_item(OP_POSITION, 1'b1, 16'h0000, 32'h0000_0000));
        wait_for_readings();
        write_scale(16'hFFFF);
        send_item(make_item(OP_SPEED,    1'b0, 16'h7FFF, 32'h0000_0001));
        send_item(make_item(OP_SPEED,    1'b0, 16'hFFFE, 32'h0000_0002));
        send_item(make_item(OP_SPEED,    1'b1, 16'h8000, 32'h8000_0000));
        send_item(make_item(OP_SPEED,    1'b1, 16'h0001, 32'h8000_0001));
        wait_for_readings();
        write_scale(16'h0000);
        send_item(make_item(OP_SPEED,    1'b0, 16'h1234, 32'h0000_03E8));
        send_item(make_item(OP_POSITION, 1'b0, 16'hA5A5, 32'h5A5A_5A5A));
        wait_for_readings();
        write_scale(16'd1);
        send_item(make_item(OP_SPEED,    1'b0, 16'hA5A6, 32'h0000_03E9));
        send_item(make_item(OP_SPEED,    1'b1, 16'h5555, 32'h0000_0000));
        wait_for_readings();
    endtask

    // Receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        repeat (PRESSURE_ITEMS)
            send_item(random_reading());
        wait_for_readings();
    endtask

    // Random traffic under several idle/stall mixes and scale settings
    task automatic test_random_phases();
        int          idle_mix  [4];
        int          stall_mix [4];
        logic [15:0] scale_mix [4];
        idle_mix  = '{0, 49, 0, 38};
        stall_mix = '{0, 0, 49, 38};
        scale_mix = '{16'hFFFF, 16'($urandom), 16'd1, 16'($urandom)};
        for (int p = 0; p < 4; p++)
        begin
            wait_for_readings();
            write_scale(scale_mix[p]);
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            repeat (PHASE_ITEMS)
                send_item(random_reading());
        end
        wait_for_readings();
        write_scale(SCALE_RESET);
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        repeat (PHASE_ITEMS / 5)
            send_item(random_reading());
    endtask

    // Receiver ready, with random stalls and forced hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted reading with the oldest prediction
    always @(posedge clk)
    begin
        eps_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected reading, expected none, actual pos %0d speed %0d flag %0b",
                         $time, out_data.position, out_data.speed, out_data.no_elapsed_time);
            end
            else
            begin
                want = pending_readings.pop_front();
                check_field("position", want.position, out_data.position);
                check_field("speed", want.speed, out_data.speed);
                check_field("no_elapsed_time", 32'(want.no_elapsed_time),
                            32'(out_data.no_elapsed_time));
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        speed_scale = SCALE_RESET;
        foreach (wheel_count[i])
        begin
            wheel_count[i] = '0;
            wheel_pos[i]   = '0;
            wheel_time[i]  = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_output_backpressure();
        test_random_phases();
        wait_for_readings();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
